// ----- sv/pv2hp_pkg.sv -----
// Shared types, codes and constants for the proxy v2 IPv4 header parser.
// This package has no dependencies. The parse core and the top level use it.
package pv2hp_pkg;

   localparam int HEADER_BYTES    = 28;
   localparam int SIGNATURE_BYTES = 12;
   localparam int POS_W           = $clog2(HEADER_BYTES);
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 4;

   // These are byte positions inside the header.
   localparam logic [POS_W-1:0] POS_SIG_LAST  = POS_W'(SIGNATURE_BYTES - 1);
   localparam logic [POS_W-1:0] POS_VER_CMD   = POS_W'(SIGNATURE_BYTES);
   localparam logic [POS_W-1:0] POS_FAM_PROTO = POS_W'(SIGNATURE_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LEN_HI    = POS_W'(SIGNATURE_BYTES + 2);
   localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(SIGNATURE_BYTES + 3);
   localparam logic [POS_W-1:0] POS_SRC_FIRST = POS_W'(SIGNATURE_BYTES + 4);
   localparam logic [POS_W-1:0] POS_SRC_LAST  = POS_W'(SIGNATURE_BYTES + 7);
   localparam logic [POS_W-1:0] POS_DST_FIRST = POS_W'(SIGNATURE_BYTES + 8);
   localparam logic [POS_W-1:0] POS_DST_LAST  = POS_W'(SIGNATURE_BYTES + 11);
   localparam logic [POS_W-1:0] POS_LAST      = POS_W'(HEADER_BYTES - 1);

   localparam logic [3:0]  VERSION_TWO   = 4'h2;
   localparam logic [3:0]  CMD_LOCAL     = 4'h0;
   localparam logic [3:0]  CMD_PROXY     = 4'h1;
   localparam logic [15:0] LENGTH_IPV4   = 16'd12;
   localparam logic [3:0]  FAMILY_RESET  = 4'h1;
   localparam logic [3:0]  PROTOCOL_RESET = 4'h1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FAMILY   = 1'b0,
      CSR_PROTOCOL = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_HEALTH    = 3'd1,
      STATUS_SIGNATURE = 3'd2,
      STATUS_VERSION   = 3'd3,
      STATUS_COMMAND   = 3'd4,
      STATUS_FAMILY    = 3'd5,
      STATUS_PROTOCOL  = 3'd6,
      STATUS_LENGTH    = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       start_flag;
   } req_word_type;

   typedef struct packed {
      status_type  parse_status;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [15:0] address_length;
   } rsp_word_type;

   typedef struct packed {
      logic last;
   } core_ctrl_type;

   // The standard twelve-byte signature.
   function automatic logic [7:0] sig_byte(input logic [3:0] idx);
      logic [7:0] value;
      case (idx)
         4'd0:    value = 8'h0D;
         4'd1:    value = 8'h0A;
         4'd2:    value = 8'h0D;
         4'd3:    value = 8'h0A;
         4'd4:    value = 8'h00;
         4'd5:    value = 8'h0D;
         4'd6:    value = 8'h0A;
         4'd7:    value = 8'h51;
         4'd8:    value = 8'h55;
         4'd9:    value = 8'h49;
         4'd10:   value = 8'h54;
         4'd11:   value = 8'h0A;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

// ----- sv/pv2hp_core.sv -----
// Parse core: byte position, first-failure status and field capture.
// Depends on pv2hp_pkg.
module pv2hp_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  pv2hp_pkg::req_word_type word,
   input  logic [3:0]              family_code,
   input  logic [3:0]              protocol_code,
   output pv2hp_pkg::core_ctrl_type ctrl,
   output pv2hp_pkg::rsp_word_type  result
);

   logic [pv2hp_pkg::POS_W-1:0] pos_ff, pos_in, pos_eff;
   pv2hp_pkg::status_type       status_ff, status_in, status_eff, status_new, fail_code;
   logic                        decided_ff, decided_in, decided_eff, decided_new, fail;
   logic [15:0]                 length_ff, length_in;
   logic [31:0]                 source_ff, source_in;
   logic [31:0]                 dest_ff, dest_in;
   logic [31:0]                 ports_ff, ports_in;
   logic [7:0]                  b;
   logic                        addr_ok;

   assign b = word.header_byte;

   // A start flag discards whatever partial header came before.
   assign pos_eff     = word.start_flag ? '0 : pos_ff;
   assign status_eff  = word.start_flag ? pv2hp_pkg::STATUS_OK : status_ff;
   assign decided_eff = word.start_flag ? 1'b0 : decided_ff;

   always_comb begin
      fail      = 1'b0;
      fail_code = pv2hp_pkg::STATUS_OK;
      length_in = length_ff;
      source_in = source_ff;
      dest_in   = dest_ff;
      ports_in  = ports_ff;
      case (pos_eff) inside
         [5'd0:pv2hp_pkg::POS_SIG_LAST]: begin
            if (b != pv2hp_pkg::sig_byte(pos_eff[3:0])) begin
               fail      = 1'b1;
               fail_code = pv2hp_pkg::STATUS_SIGNATURE;
            end
         end
         pv2hp_pkg::POS_VER_CMD: begin
            if (b[7:4] != pv2hp_pkg::VERSION_TWO) begin
               fail      = 1'b1;
               fail_code = pv2hp_pkg::STATUS_VERSION;
            end else if (b[3:0] == pv2hp_pkg::CMD_LOCAL) begin
               fail      = 1'b1;
               fail_code = pv2hp_pkg::STATUS_HEALTH;
            end else if (b[3:0] != pv2hp_pkg::CMD_PROXY) begin
               fail      = 1'b1;
               fail_code = pv2hp_pkg::STATUS_COMMAND;
            end
         end
         pv2hp_pkg::POS_FAM_PROTO: begin
            if (b[7:4] != family_code) begin
               fail      = 1'b1;
               fail_code = pv2hp_pkg::STATUS_FAMILY;
            end else if (b[3:0] != protocol_code) begin
               fail      = 1'b1;
               fail_code = pv2hp_pkg::STATUS_PROTOCOL;
            end
         end
         [pv2hp_pkg::POS_LEN_HI:pv2hp_pkg::POS_LEN_LO]: begin
            length_in = {length_ff[7:0], b};
            if (pos_eff == pv2hp_pkg::POS_LEN_LO && length_in != pv2hp_pkg::LENGTH_IPV4) begin
               fail      = 1'b1;
               fail_code = pv2hp_pkg::STATUS_LENGTH;
            end
         end
         [pv2hp_pkg::POS_SRC_FIRST:pv2hp_pkg::POS_SRC_LAST]: begin
            source_in = {source_ff[23:0], b};
         end
         [pv2hp_pkg::POS_DST_FIRST:pv2hp_pkg::POS_DST_LAST]: begin
            dest_in = {dest_ff[23:0], b};
         end
         default: begin
            ports_in = {ports_ff[23:0], b};
         end
      endcase
   end

   // Only the first failure of a header is kept.
   assign status_new  = (fail && !decided_eff) ? fail_code : status_eff;
   assign decided_new = decided_eff | fail;
   assign ctrl.last   = (pos_eff == pv2hp_pkg::POS_LAST);

   always_comb begin
      if (ctrl.last) begin
         pos_in     = '0;
         status_in  = pv2hp_pkg::STATUS_OK;
         decided_in = 1'b0;
      end else begin
         pos_in     = pos_eff + 1'b1;
         status_in  = status_new;
         decided_in = decided_new;
      end
   end

   assign addr_ok = (status_new == pv2hp_pkg::STATUS_OK) ||
                    (status_new == pv2hp_pkg::STATUS_LENGTH);

   always_comb begin
      result.parse_status        = status_new;
      result.source_address      = addr_ok ? source_ff : 32'd0;
      result.destination_address = addr_ok ? dest_ff : 32'd0;
      result.address_length      = addr_ok ? length_ff : 16'd0;
      if (status_new == pv2hp_pkg::STATUS_OK) begin
         result.source_port      = ports_in[31:16];
         result.destination_port = ports_in[15:0];
      end else begin
         result.source_port      = 16'd0;
         result.destination_port = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         status_ff  <= pv2hp_pkg::STATUS_OK;
         decided_ff <= 1'b0;
      end else if (step) begin
         pos_ff     <= pos_in;
         status_ff  <= status_in;
         decided_ff <= decided_in;
      end
   end

   // Every field store is fully rewritten before a header's result is formed.
   always_ff @(posedge clock) begin
      if (step) begin
         length_ff <= length_in;
         source_ff <= source_in;
         dest_ff   <= dest_in;
         ports_ff  <= ports_in;
      end
   end

endmodule

// ----- sv/proxy_v2_header_parser.sv -----
// Top level of the proxy v2 IPv4 header parser: handshakes, config, result register.
// Depends on pv2hp_pkg and pv2hp_core.
//
//   Channel  Direction  Handshake              Word
//   req      in         req_valid / req_ready  header_byte, start_flag
//   rsp      out        rsp_valid / rsp_ready  status, addresses, ports, length
//   csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// One header byte is taken per cycle. A taken byte is held in the input register and is
// parsed from there, and the parse state updates as it is parsed. For a header's last
// byte the result register loads together with that update, and rsp_valid rises with it.
// Reset is synchronous and returns the byte position to zero and both config registers
// to 1. Only a last byte waits on a full result register; all other bytes move on
// regardless of rsp_ready.
module proxy_v2_header_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pv2hp_pkg::req_word_type             req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pv2hp_pkg::rsp_word_type             rsp_word,
   input  logic                                csr_we,
   input  logic [pv2hp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pv2hp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                     in_valid_ff, in_valid_in;
   pv2hp_pkg::req_word_type  in_word_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   pv2hp_pkg::rsp_word_type  rsp_word_ff;
   logic [3:0]               family_ff, protocol_ff;
   pv2hp_pkg::core_ctrl_type core_ctrl;
   pv2hp_pkg::rsp_word_type  core_result;
   logic                     out_free;
   logic                     fire;
   logic                     req_take;

   // The result register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // The held byte is parsed unless it completes a header and the result
   // register cannot take another word.
   assign fire     = in_valid_ff && (!core_ctrl.last || out_free);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (fire && core_ctrl.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   pv2hp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (fire),
      .word          (in_word_ff),
      .family_code   (family_ff),
      .protocol_code (protocol_ff),
      .ctrl          (core_ctrl),
      .result        (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (fire && core_ctrl.last) begin
         rsp_word_ff <= core_result;
      end
   end

   // Configuration writes take the low four bits of the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff   <= pv2hp_pkg::FAMILY_RESET;
         protocol_ff <= pv2hp_pkg::PROTOCOL_RESET;
      end else if (csr_we) begin
         case (pv2hp_pkg::csr_index_type'(csr_index))
            pv2hp_pkg::CSR_FAMILY:   family_ff   <= csr_wdata[3:0];
            pv2hp_pkg::CSR_PROTOCOL: protocol_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- sv/pv2hp_checker.sv -----
// Port-level checks for the proxy v2 IPv4 header parser, bound to the top level.
// Depends on pv2hp_pkg and proxy_v2_header_parser.
module pv2hp_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input pv2hp_pkg::rsp_word_type rsp_word
);

   // A result word waits, unchanged, until it is taken.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("result word dropped or changed while stalled");

   property p_reset_clears;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_clears: assert property (p_reset_clears)
      else $error("result valid after reset");

   // Ports are only reported for a fully good header.
   property p_ports_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_word.parse_status != pv2hp_pkg::STATUS_OK |->
            rsp_word.source_port == 16'd0 && rsp_word.destination_port == 16'd0;
   endproperty
   a_ports_zero: assert property (p_ports_zero)
      else $error("ports reported on a failed header");

   // Addresses and length are only reported for good or bad-length headers.
   property p_addr_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_word.parse_status != pv2hp_pkg::STATUS_OK &&
         rsp_word.parse_status != pv2hp_pkg::STATUS_LENGTH |->
            rsp_word.source_address == 32'd0 && rsp_word.destination_address == 32'd0 &&
            rsp_word.address_length == 16'd0;
   endproperty
   a_addr_zero: assert property (p_addr_zero)
      else $error("addresses reported on an early failure");

endmodule

bind proxy_v2_header_parser pv2hp_checker u_pv2hp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ----- bench/header_parse_checker.sv -----
`timescale 1ns / 1ps
// Checker for the proxy v2 IPv4 header parser: watches the byte and result channels,
// predicts the result of every header and compares it. Depends on pv2hp_pkg only.
module header_parse_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  pv2hp_pkg::req_word_type             req_word,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  pv2hp_pkg::rsp_word_type             rsp_word,
   input  logic                                csr_we,
   input  logic [pv2hp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pv2hp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                  mismatch_count,
   output int                                  headers_waiting,
   output int                                  headers_checked
);

   import pv2hp_pkg::*;

   localparam logic [95:0] SIGNATURE   = 96'h0D0A_0D0A_000D_0A51_5549_540A;

   logic [3:0]   family_expect;
   logic [3:0]   protocol_expect;
   logic [4:0]   position;
   status_type   status_so_far;
   logic         decided;
   logic [15:0]  length_seen;
   logic [31:0]  source_seen;
   logic [31:0]  destination_seen;
   logic [31:0]  ports_seen;
   rsp_word_type pending_headers [$];

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("at %0d ns mismatch: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                   headers_checked, name, got, want));
      end
   endtask

   task automatic restart_header();
      position      = '0;
      status_so_far = STATUS_OK;
      decided       = 1'b0;
   endtask

   // Only the first failing check of a header sets its status.
   task automatic note_failure(input status_type code);
      if (!decided) begin
         status_so_far = code;
         decided       = 1'b1;
      end
   endtask

   task automatic track_header_byte(input req_word_type word);
      logic [7:0]   b;
      logic         keep_addresses;
      rsp_word_type result;
      b      = word.header_byte;
      result = '0;
      if (word.start_flag) begin
         restart_header();
      end
      if (position < SIGNATURE_BYTES) begin
         if (b != SIGNATURE[95 - 8 * int'(position) -: 8]) begin
            note_failure(STATUS_SIGNATURE);
         end
      end else if (position == SIGNATURE_BYTES) begin
         if (b[7:4] != VERSION_TWO) begin
            note_failure(STATUS_VERSION);
         end else if (b[3:0] == CMD_LOCAL) begin
            note_failure(STATUS_HEALTH);
         end else if (b[3:0] != CMD_PROXY) begin
            note_failure(STATUS_COMMAND);
         end
      end else if (position == SIGNATURE_BYTES + 1) begin
         if (b[7:4] != family_expect) begin
            note_failure(STATUS_FAMILY);
         end else if (b[3:0] != protocol_expect) begin
            note_failure(STATUS_PROTOCOL);
         end
      end else if (position <= SIGNATURE_BYTES + 3) begin
         length_seen = {length_seen[7:0], b};
         if (position == SIGNATURE_BYTES + 3 && length_seen != LENGTH_IPV4) begin
            note_failure(STATUS_LENGTH);
         end
      end else if (position <= SIGNATURE_BYTES + 7) begin
         source_seen = {source_seen[23:0], b};
      end else if (position <= SIGNATURE_BYTES + 11) begin
         destination_seen = {destination_seen[23:0], b};
      end else begin
         ports_seen = {ports_seen[23:0], b};
      end

      if (position == HEADER_BYTES - 1) begin
         // Addresses and length survive a length failure; ports only a clean header.
         keep_addresses = (status_so_far == STATUS_OK) || (status_so_far == STATUS_LENGTH);
         result.parse_status = status_so_far;
         if (keep_addresses) begin
            result.source_address      = source_seen;
            result.destination_address = destination_seen;
            result.address_length      = length_seen;
         end
         if (status_so_far == STATUS_OK) begin
            result.source_port      = ports_seen[31:16];
            result.destination_port = ports_seen[15:0];
         end
         pending_headers = {pending_headers, result};
         restart_header();
      end else begin
         position = position + 1'b1;
      end
   endtask

   task automatic check_result(input rsp_word_type got);
      rsp_word_type want;
      if (pending_headers.size() == 0) begin
         report_mismatch($sformatf("result with status %0d arrived while none was due",
                                   got.parse_status));
      end else begin
         want = pending_headers.pop_front();
         headers_checked++;
         compare_field("status", got.parse_status, want.parse_status);
         compare_field("source address", got.source_address, want.source_address);
         compare_field("destination address", got.destination_address,
                       want.destination_address);
         compare_field("source port", got.source_port, want.source_port);
         compare_field("destination port", got.destination_port, want.destination_port);
         compare_field("length", got.address_length, want.address_length);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         family_expect    = FAMILY_RESET;
         protocol_expect  = PROTOCOL_RESET;
         restart_header();
         length_seen      = '0;
         source_seen      = '0;
         destination_seen = '0;
         ports_seen       = '0;
         mismatch_count   = 0;
         headers_checked  = 0;
         pending_headers.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FAMILY: begin
                  family_expect = csr_wdata[3:0];
               end
               CSR_PROTOCOL: begin
                  protocol_expect = csr_wdata[3:0];
               end
               default: ;
            endcase
         end
         // A result never belongs to a byte taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_word);
         end
         if (req_valid && req_ready) begin
            track_header_byte(req_word);
         end
      end
      headers_waiting = pending_headers.size();
   end

endmodule

// ----- bench/proxy_v2_header_parser_tb.sv -----
`timescale 1ns / 1ps
// Top of the proxy v2 IPv4 header parser testbench: clock, reset, stimulus and verdict.
// Depends on pv2hp_pkg, proxy_v2_header_parser and header_parse_checker.
module proxy_v2_header_parser_tb;

   import pv2hp_pkg::*;

   // Header shapes the stimulus can build. The order matters: a second fault added
   // to a header is always one that the parser checks later than the first.
   typedef enum int {
      HDR_PROXY,
      HDR_SIGNATURE,
      HDR_VERSION,
      HDR_HEALTH,
      HDR_COMMAND,
      HDR_FAMILY,
      HDR_PROTOCOL,
      HDR_LENGTH
   } header_kind_type;

   localparam logic [95:0] SIGNATURE       = 96'h0D0A_0D0A_000D_0A51_5549_540A;
   localparam int          RESET_CYCLES    = 10;
   localparam int          ITEM_TARGET     = 1150;
   localparam int          SETTING_PHASES  = 5;
   localparam int          HOLD_OFF_CYCLES = 400;
   // Quiet stretch at the end of a settle, long enough for the last byte of a partial
   // header to pass the input register and be parsed.
   localparam int          SETTLE_CYCLES   = 6;
   localparam int          WATCHDOG_LIMIT  = 4000;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_word_type              req_word  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   int mismatch_count;
   int headers_waiting;
   int headers_checked;

   // Stimulus bookkeeping. The current register values are needed to build headers
   // that pass the family and protocol checks.
   logic [3:0] cur_family   = FAMILY_RESET;
   logic [3:0] cur_protocol = PROTOCOL_RESET;
   logic [7:0] hdr_bytes [HEADER_BYTES];
   int         bytes_sent     = 0;
   int         settings_used  = 1;
   bit         aligned        = 1'b1;
   bit         no_gaps        = 1'b0;
   bit         hold_results   = 1'b0;

   proxy_v2_header_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   header_parse_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .headers_waiting (headers_waiting),
      .headers_checked (headers_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Idle stretch lengths: mostly none or short, now and then a long one. Both the
   // byte sender and the result sink draw from this.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps) begin
         return 0;
      end else if (roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end else begin
         return $urandom_range(20, 60);
      end
   endfunction

   // Offers one word at the falling edge and holds it until the parser takes it.
   // Valid is lowered only when an idle stretch follows, so back-to-back words keep
   // valid high without a glitch.
   task automatic send_byte(input logic [7:0] value, input logic first);
      int gap;
      gap = idle_length();
      @(negedge clock);
      req_valid            = 1'b1;
      req_word.header_byte = value;
      req_word.start_flag  = first;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      bytes_sent++;
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // Sends the first count bytes of the header under construction.
   task automatic send_prefix(input bit with_start, input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(hdr_bytes[i], with_start && (i == 0));
      end
   endtask

   // Breaks the one check that the given kind names, leaving earlier checks intact.
   task automatic damage(input header_kind_type kind);
      int          pos;
      logic [15:0] len;
      case (kind)
         HDR_SIGNATURE: begin
            pos            = $urandom_range(0, SIGNATURE_BYTES - 1);
            hdr_bytes[pos] = hdr_bytes[pos] ^ 8'($urandom_range(1, 255));
         end
         HDR_VERSION: begin
            hdr_bytes[12][7:4] = hdr_bytes[12][7:4] ^ 4'($urandom_range(1, 15));
            hdr_bytes[12][3:0] = 4'($urandom);
         end
         HDR_HEALTH: begin
            hdr_bytes[12][3:0] = CMD_LOCAL;
         end
         HDR_COMMAND: begin
            hdr_bytes[12][3:0] = 4'($urandom_range(2, 15));
         end
         HDR_FAMILY: begin
            hdr_bytes[13][7:4] = hdr_bytes[13][7:4] ^ 4'($urandom_range(1, 15));
            hdr_bytes[13][3:0] = 4'($urandom);
         end
         HDR_PROTOCOL: begin
            hdr_bytes[13][3:0] = hdr_bytes[13][3:0] ^ 4'($urandom_range(1, 15));
         end
         HDR_LENGTH: begin
            len = 16'($urandom);
            if (len == LENGTH_IPV4) begin
               len = ~len;
            end
            {hdr_bytes[14], hdr_bytes[15]} = len;
         end
         default: ;
      endcase
   endtask

   // Builds a well-formed header with random addresses and ports, then applies the
   // fault of the requested kind. When stacked, a second, later fault may be added
   // so that the first failure has to win.
   task automatic build_header(input header_kind_type kind, input bit stacked);
      for (int i = 0; i < HEADER_BYTES; i++) begin
         hdr_bytes[i] = 8'($urandom);
      end
      for (int i = 0; i < SIGNATURE_BYTES; i++) begin
         hdr_bytes[i] = SIGNATURE[95 - 8 * i -: 8];
      end
      hdr_bytes[12]                  = {VERSION_TWO, CMD_PROXY};
      hdr_bytes[13]                  = {cur_family, cur_protocol};
      {hdr_bytes[14], hdr_bytes[15]} = LENGTH_IPV4;
      damage(kind);
      if (stacked && kind != HDR_PROXY && kind != HDR_LENGTH && $urandom_range(0, 1)) begin
         damage(header_kind_type'($urandom_range(int'(kind) + 1, int'(HDR_LENGTH))));
      end
   endtask

   // One random piece of traffic. Most of it is complete headers, close to half of them
   // well-formed, so the address and port capture is reached; the rest is line
   // noise with stray start flags and headers cut short by a new start.
   task automatic send_random_traffic();
      int              roll;
      int              count;
      header_kind_type kind;
      roll = $urandom_range(0, 99);
      kind = HDR_PROXY;
      if (roll >= 55) begin
         kind = header_kind_type'($urandom_range(int'(HDR_SIGNATURE), int'(HDR_LENGTH)));
      end
      if (roll < 7) begin
         count = $urandom_range(1, 40);
         repeat (count) begin
            send_byte(8'($urandom), $urandom_range(0, 7) == 0);
         end
         aligned = 1'b0;
      end else if (roll < 15) begin
         build_header(kind, 1'b1);
         send_prefix(1'b1, $urandom_range(1, HEADER_BYTES - 1));
         aligned = 1'b0;
      end else begin
         // After a complete header the parser is back at byte zero, so the start
         // flag may be left off.
         build_header(kind, 1'b1);
         send_prefix(!aligned || ($urandom_range(0, 3) != 0), HEADER_BYTES);
         aligned = 1'b1;
      end
   endtask

   // Stops offering bytes and waits until every header result has been checked and
   // any partial header has left the pipeline.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (headers_waiting != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) begin
         @(negedge clock);
      end
   endtask

   task automatic write_register(input csr_index_type idx, input logic [3:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // Result side. Ready follows random idle stretches, except when the stimulus
   // asks for a long hold-off; then ready stays low for a fixed stretch counted here
   // while the sender keeps offering bytes, so the result register fills and the
   // parser has to stall its input.
   initial begin : result_sink
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) begin
               @(negedge clock);
            end
            hold_results = 1'b0;
         end else if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            stall     = idle_length();
         end
      end
   end

   // Ends the run if no word moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no word moved for %0d cycles", quiet);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      logic [3:0] family_value;
      logic [3:0] protocol_value;

      repeat (RESET_CYCLES) begin
         @(posedge clock);
      end
      @(negedge clock);
      reset = 1'b0;

      // Directed headers at the reset setting. A clean header with all-ones fields,
      // then one with all-zero fields sent without a start flag, which must still be
      // taken from byte zero because the previous header completed.
      build_header(HDR_PROXY, 1'b0);
      for (int i = 16; i < HEADER_BYTES; i++) begin
         hdr_bytes[i] = 8'hFF;
      end
      send_prefix(1'b1, HEADER_BYTES);
      build_header(HDR_PROXY, 1'b0);
      for (int i = 16; i < HEADER_BYTES; i++) begin
         hdr_bytes[i] = 8'h00;
      end
      send_prefix(1'b0, HEADER_BYTES);

      // A health check ends the checks: a bad family after it must not change the status.
      build_header(HDR_HEALTH, 1'b0);
      damage(HDR_FAMILY);
      send_prefix(1'b1, HEADER_BYTES);

      // Each failing check on its own.
      for (int k = int'(HDR_SIGNATURE); k <= int'(HDR_LENGTH); k++) begin
         build_header(header_kind_type'(k), 1'b0);
         if (header_kind_type'(k) == HDR_LENGTH) begin
            {hdr_bytes[14], hdr_bytes[15]} = 16'hFFFF;
         end
         send_prefix(1'b1, HEADER_BYTES);
      end

      // A start flag in mid-header drops the partial header without a result.
      build_header(HDR_PROXY, 1'b0);
      send_prefix(1'b1, 20);
      build_header(HDR_PROXY, 1'b0);
      send_prefix(1'b1, HEADER_BYTES);
      settle();

      // Random traffic over several register settings: both extremes, the IPv4 family
      // with the datagram protocol code, and random values.
      for (int phase = 1; phase <= SETTING_PHASES; phase++) begin
         case (phase)
            1: begin
               family_value   = 4'h0;
               protocol_value = 4'h0;
            end
            2: begin
               family_value   = 4'hF;
               protocol_value = 4'hF;
            end
            3: begin
               family_value   = 4'h1;
               protocol_value = 4'h2;
            end
            default: begin
               family_value   = 4'($urandom);
               protocol_value = 4'($urandom);
            end
         endcase
         write_register(CSR_FAMILY, family_value);
         write_register(CSR_PROTOCOL, protocol_value);
         cur_family   = family_value;
         cur_protocol = protocol_value;
         settings_used++;

         if (phase == 2) begin
            // Long result-side hold-off with the sender pushing full headers back to back.
            no_gaps      = 1'b1;
            hold_results = 1'b1;
            repeat (4) begin
               build_header(HDR_PROXY, 1'b0);
               send_prefix(1'b1, HEADER_BYTES);
            end
            aligned = 1'b1;
            no_gaps = 1'b0;
         end

         // One phase runs with no idling on either side.
         no_gaps = (phase == 3);
         while (bytes_sent < ITEM_TARGET * phase / SETTING_PHASES) begin
            send_random_traffic();
         end
         no_gaps = 1'b0;
         // The sender pauses here until every result of this setting has come back.
         settle();
      end

      $display("Run covered %0d header bytes and %0d checked results over %0d settings",
               bytes_sent, headers_checked, settings_used);
      $display("of the family and protocol registers, with random gaps, no-gap runs and a long stall.");
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/pv2hp_pkg.sv
sv/pv2hp_core.sv
sv/proxy_v2_header_parser.sv
sv/pv2hp_checker.sv
bench/header_parse_checker.sv
bench/proxy_v2_header_parser_tb.sv
